// ----- sv/rv32_subset_core_step_assert.svh -----
// assertion macros for the rv32 subset core step
// depends on nothing; included by the top level
`ifndef RV32_SUBSET_CORE_STEP_ASSERT_SVH
`define RV32_SUBSET_CORE_STEP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RSC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define RSC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- sv/rsc_pkg.sv -----
// package for the rv32 subset core step: opcodes, codes and types
// depends on nothing
package rsc_pkg;
  localparam logic [6:0] OpcLoad   = 7'b0000011;
  localparam logic [6:0] OpcStore  = 7'b0100011;
  localparam logic [6:0] OpcReg    = 7'b0110011;
  localparam logic [6:0] OpcImm    = 7'b0010011;
  localparam logic [6:0] OpcLui    = 7'b0110111;
  localparam logic [6:0] OpcAuipc  = 7'b0010111;
  localparam logic [6:0] OpcBranch = 7'b1100011;
  localparam logic [6:0] OpcJal    = 7'b1101111;
  localparam logic [6:0] OpcJalr   = 7'b1100111;
  localparam logic [6:0] F7MulDiv  = 7'b0000001;
  localparam logic [6:0] F7Sub     = 7'b0100000;
  localparam logic [31:0] HaltMagic = 32'hDEADBEEF;
  localparam logic [1:0] HaltRun   = 2'd0;
  localparam logic [1:0] HaltZero  = 2'd1;
  localparam logic [1:0] HaltMagicCode = 2'd2;

  typedef struct packed {
    logic        start;
    logic        rem;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

// ----- sv/rv32_subset_core_step.sv -----
// rv32 subset core step: executes one instruction per request
// sequence: accept, register read, execute, then the result; loads add a data
// memory read, and div and rem wait on the divider; one instruction in flight,
// and the next request is taken only once the result has left
// the register file read and the data memory read are both registered
// reset: pc 0, registers zero with x2 at memory top, data memory undefined
`include "rv32_subset_core_step_assert.svh"
module rv32_subset_core_step
  import rsc_pkg::*;
#(
  parameter int DATA_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        instruction_valid_i,
  output logic        instruction_ready_o,
  input  logic [31:0] instruction_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [31:0] next_pc_o,
  output logic        reg_written_o,
  output logic [4:0]  dest_index_o,
  output logic [31:0] write_value_o,
  output logic        mem_written_o,
  output logic [1:0]  halt_code_o
);
  localparam int AW = $clog2(DATA_WORDS);
  localparam logic [31:0] SpTop = 32'(DATA_WORDS * 4 - 4);

  // sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [31:0] inst_q, pc_q, pc_d;
  logic [31:0] a, b;
  logic        accept, deliver;

  // result register
  logic [31:0] npc_q, npc_d, val_q, val_d;
  logic        wr_q, wr_d, mw_q, mw_d;
  logic [1:0]  halt_q, halt_d;
  // x31 shadow for the magic halt check
  logic [31:0] x31_q, x31_d;

  assign accept  = instruction_valid_i && instruction_ready_o;
  assign deliver = result_valid_o && result_ready_i;
  assign instruction_ready_o = (st_q == StIdle);
  assign result_valid_o      = (st_q == StOut);

  // decode from held instruction
  logic [6:0]  opc, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  assign opc = inst_q[6:0];
  assign rd  = inst_q[11:7];
  assign f3  = inst_q[14:12];
  assign f7  = inst_q[31:25];
  assign imm_i = {{20{inst_q[31]}}, inst_q[31:20]};
  assign imm_s = {{20{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
  assign imm_b = {{19{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25],
                  inst_q[11:8], 1'b0};
  assign imm_j = {{11{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20],
                  inst_q[30:21], 1'b0};
  assign imm_u = {inst_q[31:12], 12'd0};

  // register file, read addresses taken straight from the request
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  rsc_regfile #(.SpReset(SpTop)) u_rf (
    .clk_i, .rst_ni,
    .ra_i(instruction_i[19:15]), .rb_i(instruction_i[24:20]),
    .we_i(rf_we), .wa_i(rf_wa), .wd_i(rf_wd),
    .a_o(a), .b_o(b)
  );

  // operands held once read
  logic [31:0] a_q, b_q;

  // divider
  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_res;
  rsc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .result_o(div_res));

  // data memory, word-addressed, read data registered
  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] dmem_rd_q;
  logic        dm_we;
  logic [AW-1:0] dm_addr;
  logic [31:0] addr_ld, addr_st;
  assign addr_ld = a_q + imm_i;
  assign addr_st = a_q + imm_s;
  assign dm_addr = (opc == OpcStore) ? addr_st[AW+1:2] : addr_ld[AW+1:2];

  always_ff @(posedge clk_i) begin
    if (dm_we) dmem[dm_addr] <= b_q;
    dmem_rd_q <= dmem[dm_addr];
  end

  // alu
  logic [31:0] alu_b, alu_res, prod;
  logic        is_reg, is_div, taken;
  assign is_reg = (opc == OpcReg);
  assign alu_b  = is_reg ? b_q : imm_i;
  assign prod   = a_q * b_q;
  assign is_div = is_reg && (f7 == F7MulDiv) && (f3 == 3'd4 || f3 == 3'd6);

  always_comb begin
    if (is_reg && f7 == F7MulDiv) begin
      alu_res = (f3 == 3'd0) ? prod : a_q + alu_b;
    end else if (is_reg && f7 == F7Sub) begin
      alu_res = (f3 == 3'd0) ? a_q - alu_b : a_q + alu_b;
    end else if (is_reg && f7 != 7'd0) begin
      alu_res = a_q + alu_b;
    end else begin
      case (f3)
        3'd1:    alu_res = a_q << alu_b[4:0];
        3'd5:    alu_res = a_q >> alu_b[4:0];
        3'd4:    alu_res = a_q ^ alu_b;
        3'd6:    alu_res = a_q | alu_b;
        3'd7:    alu_res = a_q & alu_b;
        default: alu_res = a_q + alu_b;
      endcase
    end
  end

  always_comb begin
    case (f3)
      3'd0:    taken = (a_q == b_q);
      3'd1:    taken = (a_q != b_q);
      3'd4:    taken = $signed(a_q) < $signed(b_q);
      3'd5:    taken = $signed(a_q) >= $signed(b_q);
      3'd6:    taken = a_q < b_q;
      3'd7:    taken = a_q >= b_q;
      default: taken = 1'b0;
    endcase
  end

  // sequencer
  logic [31:0] ex_val, ex_npc;
  logic        ex_wr;
  logic        fin;
  always_comb begin
    st_d = st_q; pc_d = pc_q;
    npc_d = npc_q; val_d = val_q; wr_d = wr_q; mw_d = mw_q; halt_d = halt_q;
    x31_d = x31_q;
    rf_we = 1'b0; rf_wa = rd; rf_wd = '0; dm_we = 1'b0;
    div_req = '{start: 1'b0, rem: f3[1], dividend: a_q, divisor: b_q};
    ex_val = '0; ex_wr = 1'b0; ex_npc = pc_q + 32'd4; fin = 1'b0;

    unique case (opc) inside
      OpcReg, OpcImm: begin ex_val = alu_res; ex_wr = 1'b1; end
      OpcLui:   begin ex_val = imm_u; ex_wr = 1'b1; end
      OpcAuipc: begin ex_val = pc_q + imm_u; ex_wr = 1'b1; end
      OpcJal:   begin ex_val = pc_q + 32'd4; ex_wr = 1'b1; ex_npc = pc_q + imm_j; end
      OpcJalr:  begin
        ex_val = pc_q + 32'd4; ex_wr = 1'b1;
        ex_npc = addr_ld & 32'hFFFF_FFFE;
      end
      OpcBranch: if (taken) ex_npc = pc_q + imm_b;
      default: ;
    endcase

    unique case (st_q)
      StIdle: if (accept) st_d = StRead;
      StRead: st_d = StExec;
      StExec: begin
        if (inst_q == 32'd0) begin
          npc_d = pc_q; val_d = '0; wr_d = 1'b0; mw_d = 1'b0; halt_d = HaltZero;
          st_d = StOut;
        end else if (opc == OpcLoad) begin
          st_d = StLoad;
        end else if (is_div) begin
          div_req.start = 1'b1;
          st_d = StDiv;
        end else begin
          dm_we = (opc == OpcStore);
          mw_d = (opc == OpcStore);
          fin = 1'b1;
        end
      end
      StLoad: begin ex_val = dmem_rd_q; ex_wr = 1'b1; mw_d = 1'b0; fin = 1'b1; end
      StDiv: if (div_done) begin
        ex_val = div_res; ex_wr = 1'b1; mw_d = 1'b0; fin = 1'b1;
      end
      StOut: if (deliver) st_d = StIdle;
      default: st_d = StIdle;
    endcase

    if (fin) begin
      wr_d  = ex_wr && (rd != 5'd0);
      val_d = wr_d ? ex_val : 32'd0;
      npc_d = ex_npc;
      pc_d  = ex_npc;
      rf_we = wr_d; rf_wd = ex_val;
      if (wr_d && rd == 5'd31) x31_d = ex_val;
      halt_d = (x31_d == HaltMagic) ? HaltMagicCode : HaltRun;
      st_d = StOut;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pc_q <= '0; x31_q <= '0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; x31_q <= x31_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) inst_q <= instruction_i;
    if (st_q == StRead) begin
      a_q <= a; b_q <= b;
    end
    npc_q <= npc_d; val_q <= val_d; wr_q <= wr_d; mw_q <= mw_d; halt_q <= halt_d;
  end

  assign next_pc_o     = npc_q;
  assign reg_written_o = wr_q;
  assign dest_index_o  = wr_q ? inst_q[11:7] : 5'd0;
  assign write_value_o = val_q;
  assign mem_written_o = mw_q;
  assign halt_code_o   = halt_q;

  `RSC_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, result_valid_o, !instruction_ready_o)
  `RSC_ASSERT_NEXT(a_pc_hold, clk_i, rst_ni, st_q == StOut, $stable(pc_q))
  `RSC_ASSERT_IMP(a_no_x0, clk_i, rst_ni, rf_we, rf_wa != 5'd0)
endmodule

// ----- sv/rsc_div.sv -----
// unsigned iterative divider, one quotient bit per cycle
// depends on rsc_pkg
module rsc_div
  import rsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [31:0] result_o
);
  logic [31:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, sel_q, sel_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; sel_d = sel_q;
    trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d = req_i.dividend; rem_d = '0; dvs_d = req_i.divisor;
      cnt_d = 6'd32; busy_d = 1'b1; sel_d = req_i.rem;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sel_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
  end

  // divide by zero falls out of restoring division: all ones and the dividend
  assign done_o   = done_q;
  assign result_o = sel_q ? rem_q : quo_q;
endmodule

// ----- sv/rsc_regfile.sv -----
// 32 x 32 register file, synchronous read with valid bits for reset values
// depends on rsc_pkg
module rsc_regfile
  import rsc_pkg::*;
#(
  parameter logic [31:0] SpReset = 32'd4092
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  ra_i,
  input  logic [4:0]  rb_i,
  input  logic        we_i,
  input  logic [4:0]  wa_i,
  input  logic [31:0] wd_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o
);
  logic [31:0] mem_a [32];
  logic [31:0] mem_b [32];
  logic [31:0] rda_q, rdb_q;
  logic [31:0] vld_q;
  logic        va_q, vb_q;
  logic [4:0]  ra_q, rb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_a[wa_i] <= wd_i;
      mem_b[wa_i] <= wd_i;
    end
    rda_q <= mem_a[ra_i];
    rdb_q <= mem_b[rb_i];
    ra_q  <= ra_i;
    rb_q  <= rb_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; va_q <= 1'b0; vb_q <= 1'b0;
    end else begin
      va_q <= vld_q[ra_i];
      vb_q <= vld_q[rb_i];
      if (we_i) vld_q[wa_i] <= 1'b1;
    end
  end

  assign a_o = va_q ? rda_q : ((ra_q == 5'd2) ? SpReset : 32'd0);
  assign b_o = vb_q ? rdb_q : ((rb_q == 5'd2) ? SpReset : 32'd0);
endmodule

// ----- sim/tb_rv32_subset_core_step.sv -----
// self-checking testbench for rv32_subset_core_step
// depends on rsc_pkg and the rv32_subset_core_step rtl; reads no files
// directed instructions first, then random ones mostly well formed, checked field by field
module tb_rv32_subset_core_step;
  import rsc_pkg::*;

  localparam int MemWords = 1024;
  localparam int RandomItems = 1900;
  localparam logic [2:0] F3Add = 3'd0, F3Sll = 3'd1, F3Slt = 3'd2, F3Xor = 3'd4,
                         F3Srl = 3'd5, F3Or = 3'd6, F3And = 3'd7, F3Word = 3'd2;
  localparam logic [2:0] F3Beq = 3'd0, F3Blt = 3'd4, F3Bgeu = 3'd7;
  localparam logic [6:0] F7Base = 7'd0;
  localparam logic [6:0] OpcUnknown = 7'b1111111;

  // one request as the sender holds it: word, gap before it, and whether it
  // waits for every outstanding result first
  typedef struct {
    logic [31:0] word;
    int unsigned gap;
    bit          drain;
  } instr_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] write_value;
    logic        mem_written;
    logic [1:0]  halt_code;
  } retire_t;

  logic        clk_i;
  logic        rst_ni;
  logic        instruction_valid_i;
  logic        instruction_ready_o;
  logic [31:0] instruction_i;
  logic        result_valid_o;
  logic        result_ready_i;
  logic [31:0] next_pc_o;
  logic        reg_written_o;
  logic [4:0]  dest_index_o;
  logic [31:0] write_value_o;
  logic        mem_written_o;
  logic [1:0]  halt_code_o;

  rv32_subset_core_step #(.DATA_WORDS(MemWords)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .instruction_valid_i(instruction_valid_i),
    .instruction_ready_o(instruction_ready_o),
    .instruction_i      (instruction_i),
    .result_valid_o     (result_valid_o),
    .result_ready_i     (result_ready_i),
    .next_pc_o          (next_pc_o),
    .reg_written_o      (reg_written_o),
    .dest_index_o       (dest_index_o),
    .write_value_o      (write_value_o),
    .mem_written_o      (mem_written_o),
    .halt_code_o        (halt_code_o)
  );

  // architectural state as the testbench sees it
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [31:0] arch_mem [MemWords];

  instr_req_t  pending_instr[$];
  retire_t     expected_retire[$];
  int unsigned issued_count;
  int unsigned retired_count;
  int unsigned mismatch_count;
  bit          hold_receiver;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [31:0] sext12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // executes one instruction on the architectural state and returns what retires
  function automatic retire_t exec_instruction(logic [31:0] w);
    retire_t     r;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, val, nxt, addr;
    logic        wr, mw, taken;
    opc   = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    f7    = w[31:25];
    a     = arch_regs[w[19:15]];
    b     = arch_regs[w[24:20]];
    imm_i = sext12(w[31:20]);
    imm_s = sext12({w[31:25], w[11:7]});
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    nxt   = arch_pc + 32'd4;
    val   = '0;
    wr    = 1'b0;
    mw    = 1'b0;
    r     = '0;
    if (w == '0) begin
      r.next_pc   = arch_pc;
      r.halt_code = HaltZero;
      return r;
    end
    case (opc)
      OpcLoad: begin
        addr = a + imm_i;
        val  = arch_mem[addr[11:2]];
        wr   = 1'b1;
      end
      OpcStore: begin
        addr = a + imm_s;
        arch_mem[addr[11:2]] = b;
        mw = 1'b1;
      end
      OpcReg, OpcImm: begin
        if (opc == OpcImm) begin
          b  = imm_i;
          f7 = F7Base;
        end
        wr = 1'b1;
        if (f7 == F7MulDiv) begin
          case (f3)
            F3Add:   val = a * b;
            F3Xor:   val = (b == '0) ? 32'hFFFF_FFFF : a / b;
            F3Or:    val = (b == '0) ? a : a % b;
            default: val = a + b;
          endcase
        end else if (f7 == F7Sub) begin
          val = (f3 == F3Add) ? a - b : a + b;
        end else if (f7 != F7Base) begin
          val = a + b;
        end else begin
          case (f3)
            F3Sll:   val = a << b[4:0];
            F3Srl:   val = a >> b[4:0];
            F3Xor:   val = a ^ b;
            F3Or:    val = a | b;
            F3And:   val = a & b;
            default: val = a + b;
          endcase
        end
      end
      OpcLui: begin
        val = {w[31:12], 12'd0};
        wr  = 1'b1;
      end
      OpcAuipc: begin
        val = arch_pc + {w[31:12], 12'd0};
        wr  = 1'b1;
      end
      OpcBranch: begin
        case (f3)
          3'd0:    taken = (a == b);
          3'd1:    taken = (a != b);
          3'd4:    taken = ($signed(a) < $signed(b));
          3'd5:    taken = ($signed(a) >= $signed(b));
          3'd6:    taken = (a < b);
          3'd7:    taken = (a >= b);
          default: taken = 1'b0;
        endcase
        if (taken) nxt = arch_pc + imm_b;
      end
      OpcJal: begin
        val = arch_pc + 32'd4;
        wr  = 1'b1;
        nxt = arch_pc + imm_j;
      end
      OpcJalr: begin
        val = arch_pc + 32'd4;
        wr  = 1'b1;
        nxt = (a + imm_i) & 32'hFFFF_FFFE;
      end
      default: ;
    endcase
    if (rd == '0) wr = 1'b0;
    if (wr) arch_regs[rd] = val;
    arch_pc = nxt;
    r.next_pc     = nxt;
    r.reg_written = wr;
    r.dest_index  = wr ? rd : '0;
    r.write_value = wr ? val : '0;
    r.mem_written = mw;
    r.halt_code   = (arch_regs[31] == HaltMagic) ? HaltMagicCode : HaltRun;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3Word, imm[4:0], OpcStore};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpcBranch};
  endfunction

  // words written so far by stores through x0, the only ones a load may read
  bit          mem_filled [MemWords];
  int unsigned filled_list[$];

  function automatic logic [31:0] store_via_x0(logic [11:0] imm, logic [4:0] rs2);
    logic [31:0] addr;
    addr = sext12(imm);
    if (!mem_filled[addr[11:2]]) begin
      mem_filled[addr[11:2]] = 1'b1;
      filled_list.push_back(32'(addr[11:2]));
    end
    return enc_s(imm, rs2, 5'd0);
  endfunction

  function automatic logic [31:0] load_via_x0(logic [4:0] rd);
    logic [9:0] idx;
    idx = 10'(filled_list[$urandom_range(0, filled_list.size() - 1)]);
    return enc_i({idx, 2'($urandom_range(0, 3))}, 5'd0, F3Word, rd, OpcLoad);
  endfunction

  function automatic logic [31:0] random_instruction();
    int unsigned k;
    logic [31:0] w;
    logic [6:0]  f7;
    k = $urandom_range(0, 99);
    w = $urandom();
    if (k < 15) begin
      if (k < 6) w = {w[31:12], w[11:7], OpcLui};
      else w = enc_i(w[31:20], w[19:15], F3Add, w[11:7], OpcImm);
    end else if (k < 45) begin
      case ($urandom_range(0, 3))
        0:       f7 = F7Base;
        1:       f7 = F7Sub;
        2:       f7 = F7MulDiv;
        default: f7 = w[31:25];
      endcase
      w = enc_r(f7, w[24:20], w[19:15], w[14:12], w[11:7], OpcReg);
    end else if (k < 58) begin
      w = {w[31:7], OpcImm};
    end else if (k < 70) begin
      // stores through a live register land anywhere; loads aim only at words stored via x0
      if (k < 66) w = store_via_x0(w[31:20], w[24:20]);
      else w = enc_s(w[31:20], w[24:20], w[19:15]);
    end else if (k < 80) begin
      if (filled_list.size() > 0) w = load_via_x0(w[11:7]);
      else w = store_via_x0(w[31:20], w[24:20]);
    end else if (k < 87) begin
      w = {w[31:7], OpcBranch};
    end else if (k < 93) begin
      case (k % 3)
        0:       w = {w[31:7], OpcJal};
        1:       w = {w[31:15], F3Add, w[11:7], OpcJalr};
        default: w = {w[31:7], OpcAuipc};
      endcase
    end else if (k < 98) begin
      // noise, but never a load with an unknown base
      if (w[6:0] == OpcLoad) w[6:0] = OpcUnknown;
    end else begin
      w = '0;
    end
    return w;
  endfunction

  function automatic void queue_instr(logic [31:0] w, int unsigned gap, bit drain);
    instr_req_t q;
    q.word  = w;
    q.gap   = gap;
    q.drain = drain;
    pending_instr.push_back(q);
  endfunction

  // stimulus: directed sequence first, then the random body
  initial begin
    logic [31:0] dir[$];
    int unsigned gap;
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_regs[2] = MemWords * 4 - 4;
    arch_pc = '0;
    for (int i = 0; i < MemWords; i++) arch_mem[i] = '0;
    dir.push_back({20'hFFFFF, 5'd1, OpcLui});                          // x1 = ffff_f000
    dir.push_back(enc_i(12'hFFF, 5'd1, F3Add, 5'd1, OpcImm));          // x1 = ffff_efff
    dir.push_back(enc_i(12'h7FF, 5'd0, F3Add, 5'd3, OpcImm));          // largest positive imm
    dir.push_back(enc_r(F7Base, 5'd3, 5'd1, F3Add, 5'd4, OpcReg));
    dir.push_back(enc_r(F7Sub, 5'd3, 5'd1, F3Add, 5'd5, OpcReg));
    dir.push_back(enc_r(F7MulDiv, 5'd3, 5'd1, F3Add, 5'd6, OpcReg));   // mul
    dir.push_back(enc_r(F7MulDiv, 5'd0, 5'd1, F3Xor, 5'd7, OpcReg));   // div by zero
    dir.push_back(enc_r(F7MulDiv, 5'd0, 5'd1, F3Or, 5'd8, OpcReg));    // rem by zero
    dir.push_back(enc_r(F7MulDiv, 5'd3, 5'd1, F3Xor, 5'd9, OpcReg));
    dir.push_back(enc_r(F7MulDiv, 5'd3, 5'd1, F3Or, 5'd10, OpcReg));
    dir.push_back(enc_r(F7Base, 5'd1, 5'd3, F3Sll, 5'd11, OpcReg));    // shift by low 5 bits
    dir.push_back(enc_r(F7Base, 5'd3, 5'd1, F3Srl, 5'd12, OpcReg));
    dir.push_back(enc_r(F7Sub, 5'd3, 5'd1, F3Srl, 5'd13, OpcReg));     // sra acts as add
    dir.push_back(enc_i({F7Sub, 5'd31}, 5'd1, F3Srl, 5'd14, OpcImm));  // srai acts as srli
    dir.push_back(enc_r(F7Base, 5'd3, 5'd1, F3Xor, 5'd15, OpcReg));
    dir.push_back(enc_r(F7Base, 5'd3, 5'd1, F3Or, 5'd16, OpcReg));
    dir.push_back(enc_r(F7Base, 5'd3, 5'd1, F3And, 5'd17, OpcReg));
    dir.push_back(enc_r(F7Base, 5'd3, 5'd1, F3Slt, 5'd18, OpcReg));    // unlisted funct3
    dir.push_back(store_via_x0(12'hFFC, 5'd1));                        // wraps to the top word
    dir.push_back(enc_i(12'hFFF, 5'd0, F3Word, 5'd19, OpcLoad));       // low bits ignored
    dir.push_back({20'h80000, 5'd20, OpcAuipc});
    dir.push_back({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd21, OpcJal});
    dir.push_back(enc_i(12'h7FF, 5'd1, F3Add, 5'd22, OpcJalr));
    dir.push_back(enc_b(13'h0010, 5'd0, 5'd0, F3Beq));
    dir.push_back(enc_b(13'h1FF0, 5'd3, 5'd1, F3Blt));                 // signed compare
    dir.push_back(enc_b(13'h0008, 5'd3, 5'd1, F3Bgeu));
    dir.push_back(enc_b(13'h0008, 5'd0, 5'd0, F3Slt));                 // never taken
    dir.push_back({25'h1ABCDEF, OpcUnknown});
    dir.push_back(enc_i(12'h123, 5'd0, F3Add, 5'd0, OpcImm));          // x0 stays zero
    dir.push_back('0);                                                 // zero instruction
    dir.push_back({20'hDEADC, 5'd31, OpcLui});
    dir.push_back(enc_i(12'hEEF, 5'd31, F3Add, 5'd31, OpcImm));        // x31 = magic
    dir.push_back(enc_r(F7Base, 5'd3, 5'd1, F3Add, 5'd4, OpcReg));
    dir.push_back(enc_i(12'h000, 5'd0, F3Add, 5'd31, OpcImm));
    foreach (dir[i]) queue_instr(dir[i], $urandom_range(0, 3), 1'b0);
    // random body: phases with and without gaps, an occasional full drain
    for (int i = 0; i < RandomItems; i++) begin
      gap = ((i / 150) % 3 == 0) ? 0 : $urandom_range(0, 16);
      queue_instr(random_instruction(), gap, (i % 400) == 399);
    end
  end

  // sender
  bit          staged;
  instr_req_t  staged_req;
  int unsigned staged_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    logic       nxt_valid;
    retire_t    exp_r;
    if (!rst_ni) begin
      instruction_valid_i <= 1'b0;
      instruction_i       <= '0;
      staged              = 1'b0;
      staged_wait         = 0;
      issued_count        = 0;
    end else begin
      nxt_valid = instruction_valid_i;
      if (instruction_valid_i && instruction_ready_o) begin
        exp_r = exec_instruction(instruction_i);
        expected_retire.push_back(exp_r);
        issued_count++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (!staged && pending_instr.size() > 0) begin
          staged_req  = pending_instr.pop_front();
          staged_wait = staged_req.gap;
          staged      = 1'b1;
        end
        if (staged) begin
          if (staged_wait > 0) begin
            staged_wait--;
          end else if (!staged_req.drain || issued_count == retired_count) begin
            // a drain request waits until every outstanding result has come back
            nxt_valid = 1'b1;
            instruction_i <= staged_req.word;
            staged = 1'b0;
          end
        end
      end
      instruction_valid_i <= nxt_valid;
    end
  end

  // long receiver hold-off, counted on its own, so the core backs up its input
  int unsigned cycle_count;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_count   = 0;
      hold_receiver <= 1'b0;
    end else begin
      cycle_count++;
      hold_receiver <= (cycle_count >= 2000 && cycle_count < 2400);
    end
  end

  // receiver and checker
  int unsigned stall_left;

  function automatic void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on result %0d, %s: expected %h, got %h",
                 retired_count, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    retire_t exp_r;
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
      stall_left     = 0;
      retired_count  = 0;
      mismatch_count = 0;
    end else begin
      if (result_valid_o && result_ready_i) begin
        if (expected_retire.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result with no request outstanding");
        end else begin
          exp_r = expected_retire.pop_front();
          report_field("next_pc", exp_r.next_pc, next_pc_o);
          report_field("reg_written", 32'(exp_r.reg_written), 32'(reg_written_o));
          report_field("dest_index", 32'(exp_r.dest_index), 32'(dest_index_o));
          report_field("write_value", exp_r.write_value, write_value_o);
          report_field("mem_written", 32'(exp_r.mem_written), 32'(mem_written_o));
          report_field("halt_code", 32'(exp_r.halt_code), 32'(halt_code_o));
        end
        retired_count++;
        // stall-free stretches alternate with randomly stalled ones
        stall_left = ((retired_count / 130) % 3 == 1) ? 0 : $urandom_range(0, 16);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= !hold_receiver;
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    do @(posedge clk_i);
    while (pending_instr.size() > 0 || staged || instruction_valid_i
           || issued_count != retired_count);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && expected_retire.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
